// ===== sv/ppmu_pkg.sv =====
// Shared types and constants for the particle pose motion update pipeline.
// Holds the per-particle payload type, CORDIC constants and register codes.
// No dependencies.
package ppmu_pkg;

  // Register codes, taken from paddr[3:2].
  localparam logic [1:0] REG_DISP_X       = 2'd0;
  localparam logic [1:0] REG_DISP_Y       = 2'd1;
  localparam logic [1:0] REG_DISP_HEADING = 2'd2;

  localparam int ADDR_W = 4;

  localparam logic [15:0] DISP_X_RESET       = 16'd3277;
  localparam logic [15:0] DISP_Y_RESET       = 16'd3277;
  localparam logic [13:0] DISP_HEADING_RESET = 14'd500;

  // Widths of the CORDIC vector (Q2.30 plus headroom) and residual angle.
  localparam int VEC_W = 33;
  localparam int ANG_W = 34;
  localparam int ATAN_LEN = 24;

  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;

  // Rounding offsets for the Q30 rotation result; the negative form folds
  // the two's complement negation into the same add.
  localparam logic [61:0] ROUND_POS = 62'd536870912;
  localparam logic [61:0] ROUND_NEG = 62'd536870913;
  localparam logic signed [43:0] ROUND_NOISE_XY = 44'sd2048;
  localparam logic signed [27:0] ROUND_NOISE_H  = 28'sd2048;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        pose_heading;
    logic signed [31:0] step_forward;
    logic signed [31:0] step_lateral;
    logic [15:0]        step_turn;
    logic [31:0]        noise_x;
    logic [31:0]        noise_y;
    logic [15:0]        noise_heading;
    logic               batch_last;
    logic               neg;
  } item_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ppmu_if.sv =====
// Valid/ready channel interfaces for particles in and updated poses out.
// Standalone; no package dependency.
interface ppmu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0]        pose_heading;
  logic signed [31:0] step_forward;
  logic signed [31:0] step_lateral;
  logic [15:0]        step_turn;
  logic signed [15:0] draw_x;
  logic signed [15:0] draw_y;
  logic signed [15:0] draw_heading;
  logic               batch_last;

  modport source (
    output valid, pose_x, pose_y, pose_heading, step_forward, step_lateral,
           step_turn, draw_x, draw_y, draw_heading, batch_last,
    input  ready
  );
  modport sink (
    input  valid, pose_x, pose_y, pose_heading, step_forward, step_lateral,
           step_turn, draw_x, draw_y, draw_heading, batch_last,
    output ready
  );
endinterface

interface ppmu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic [15:0]        new_heading;
  logic               batch_end;

  modport source (
    output valid, new_x, new_y, new_heading, batch_end,
    input  ready
  );
  modport sink (
    input  valid, new_x, new_y, new_heading, batch_end,
    output ready
  );
endinterface

// ===== sv/ppmu_apb_regs.sv =====
// APB-style register file holding the three noise dispersion settings.
// Depends on ppmu_pkg for register codes and reset values.
module ppmu_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppmu_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [15:0]                  disp_x,
  output logic [15:0]                  disp_y,
  output logic [13:0]                  disp_heading
);

  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_x       <= ppmu_pkg::DISP_X_RESET;
      disp_y       <= ppmu_pkg::DISP_Y_RESET;
      disp_heading <= ppmu_pkg::DISP_HEADING_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        ppmu_pkg::REG_DISP_X:       disp_x       <= pwdata[15:0];
        ppmu_pkg::REG_DISP_Y:       disp_y       <= pwdata[15:0];
        ppmu_pkg::REG_DISP_HEADING: disp_heading <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ppmu_pkg::REG_DISP_X:       prdata = {16'd0, disp_x};
      ppmu_pkg::REG_DISP_Y:       prdata = {16'd0, disp_y};
      ppmu_pkg::REG_DISP_HEADING: prdata = {18'd0, disp_heading};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/ppmu_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with its register stage.
// Carries the particle payload alongside; depends on ppmu_pkg.
module ppmu_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  valid_in,
  input  ppmu_pkg::vec_t        vec_in,
  input  ppmu_pkg::item_t       item_in,
  output logic                  valid_out,
  output ppmu_pkg::vec_t        vec_out,
  output ppmu_pkg::item_t       item_out
);

  logic signed [ppmu_pkg::ANG_W-1:0] step_angle;
  logic signed [ppmu_pkg::VEC_W-1:0] x_sh;
  logic signed [ppmu_pkg::VEC_W-1:0] y_sh;
  ppmu_pkg::vec_t                    vec_next;

  assign step_angle = $signed({2'b00, ppmu_pkg::atan_turn(SHIFT)});
  assign x_sh = vec_in.x >>> SHIFT;
  assign y_sh = vec_in.y >>> SHIFT;

  // A residual of zero counts as positive and turns counterclockwise.
  always_comb begin
    if (!vec_in.z[ppmu_pkg::ANG_W-1]) begin
      vec_next.x = vec_in.x - y_sh;
      vec_next.y = vec_in.y + x_sh;
      vec_next.z = vec_in.z - step_angle;
    end else begin
      vec_next.x = vec_in.x + y_sh;
      vec_next.y = vec_in.y - x_sh;
      vec_next.z = vec_in.z + step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vec_out  <= vec_next;
      item_out <= item_in;
    end
  end

endmodule

// ===== sv/particle_pose_motion_update.sv =====
// Particle pose motion update: one particle enters per cycle unless the output
// stalls, and its updated pose passes through an input stage, a chain of NSTAGE
// CORDIC cells, where NSTAGE is CORDIC_STAGES capped at 24, a multiply stage,
// a sum stage, a rounding stage and the output register.
// The whole pipeline moves as one: it holds while a finished pose waits at
// the output, so particles.ready follows updates.ready combinationally.
// Dispersion registers are written over the APB port at byte addresses 0, 4
// and 8 and must be changed only while no particle is in flight.
// Depends on ppmu_pkg, ppmu_if, ppmu_apb_regs and ppmu_cordic_cell.
module particle_pose_motion_update #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  ppmu_in_if.sink                      particles,
  ppmu_out_if.source                   updates,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppmu_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int NSTAGE = (CORDIC_STAGES > ppmu_pkg::ATAN_LEN) ?
                          ppmu_pkg::ATAN_LEN : CORDIC_STAGES;

  logic [15:0] disp_x;
  logic [15:0] disp_y;
  logic [13:0] disp_heading;

  ppmu_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .disp_x       (disp_x),
    .disp_y       (disp_y),
    .disp_heading (disp_heading)
  );

  logic advance;

  assign advance         = !updates.valid || updates.ready;
  assign particles.ready = advance;

  // Input stage: quadrant fold, CORDIC seed and rounded noise terms.
  logic signed [15:0]  head_s;
  logic signed [15:0]  head_red;
  logic                head_neg;
  logic signed [16:0]  dx_scale;
  logic signed [16:0]  dy_scale;
  logic signed [14:0]  dh_scale;
  logic signed [32:0]  nx_prod;
  logic signed [32:0]  ny_prod;
  logic signed [30:0]  nh_prod;
  logic signed [43:0]  nx_sum;
  logic signed [43:0]  ny_sum;
  logic signed [27:0]  nh_sum;
  ppmu_pkg::item_t     item_seed;
  ppmu_pkg::vec_t      vec_seed;

  assign head_s   = $signed(particles.pose_heading);
  assign head_neg = (head_s > ppmu_pkg::QUARTER_TURN) || (head_s < -ppmu_pkg::QUARTER_TURN);
  // Adding or removing half a turn only flips the top bit of a binary angle.
  assign head_red = head_neg ? $signed({~head_s[15], head_s[14:0]}) : head_s;

  assign dx_scale = $signed({1'b0, disp_x});
  assign dy_scale = $signed({1'b0, disp_y});
  assign dh_scale = $signed({1'b0, disp_heading});
  assign nx_prod  = particles.draw_x * dx_scale;
  assign ny_prod  = particles.draw_y * dy_scale;
  assign nh_prod  = particles.draw_heading * dh_scale;
  assign nx_sum   = 44'(nx_prod) + ppmu_pkg::ROUND_NOISE_XY;
  assign ny_sum   = 44'(ny_prod) + ppmu_pkg::ROUND_NOISE_XY;
  assign nh_sum   = 28'(nh_prod) + ppmu_pkg::ROUND_NOISE_H;

  always_comb begin
    vec_seed.x = ppmu_pkg::CORDIC_GAIN;
    vec_seed.y = '0;
    vec_seed.z = $signed({{2{head_red[15]}}, head_red, 16'h0000});
    item_seed.pose_x        = particles.pose_x;
    item_seed.pose_y        = particles.pose_y;
    item_seed.pose_heading  = particles.pose_heading;
    item_seed.step_forward  = particles.step_forward;
    item_seed.step_lateral  = particles.step_lateral;
    item_seed.step_turn     = particles.step_turn;
    item_seed.noise_x       = nx_sum[43:12];
    item_seed.noise_y       = ny_sum[43:12];
    item_seed.noise_heading = nh_sum[27:12];
    item_seed.batch_last    = particles.batch_last;
    item_seed.neg           = head_neg;
  end

  logic             s0_valid;
  ppmu_pkg::vec_t   s0_vec;
  ppmu_pkg::item_t  s0_item;
  logic [NSTAGE:0]  vld;
  ppmu_pkg::vec_t   vec  [NSTAGE+1];
  ppmu_pkg::item_t  item [NSTAGE+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= particles.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_vec  <= vec_seed;
      s0_item <= item_seed;
    end
  end

  assign vld[0]  = s0_valid;
  assign vec[0]  = s0_vec;
  assign item[0] = s0_item;

  for (genvar g = 0; g < NSTAGE; g++) begin : g_cell
    ppmu_cordic_cell #(.SHIFT(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .valid_in  (vld[g]),
      .vec_in    (vec[g]),
      .item_in   (item[g]),
      .valid_out (vld[g+1]),
      .vec_out   (vec[g+1]),
      .item_out  (item[g+1])
    );
  end

  // Multiply stage: the four rotation products, kept modulo 2^62.
  logic signed [64:0] xf_full;
  logic signed [64:0] yl_full;
  logic signed [64:0] yf_full;
  logic signed [64:0] xl_full;
  logic               m_valid;
  logic [61:0]        m_xf;
  logic [61:0]        m_yl;
  logic [61:0]        m_yf;
  logic [61:0]        m_xl;
  ppmu_pkg::item_t    m_item;

  assign xf_full = vec[NSTAGE].x * item[NSTAGE].step_forward;
  assign yl_full = vec[NSTAGE].y * item[NSTAGE].step_lateral;
  assign yf_full = vec[NSTAGE].y * item[NSTAGE].step_forward;
  assign xl_full = vec[NSTAGE].x * item[NSTAGE].step_lateral;

  // Sum stage.
  logic               a_valid;
  logic [61:0]        a_tx;
  logic [61:0]        a_ty;
  ppmu_pkg::item_t    a_item;

  // Rounding stage; a folded quadrant negates both sums here.
  logic [61:0]        tx_round;
  logic [61:0]        ty_round;
  logic               r_valid;
  logic [31:0]        r_dx;
  logic [31:0]        r_dy;
  ppmu_pkg::item_t    r_item;

  assign tx_round = a_item.neg ? (~a_tx + ppmu_pkg::ROUND_NEG) : (a_tx + ppmu_pkg::ROUND_POS);
  assign ty_round = a_item.neg ? (~a_ty + ppmu_pkg::ROUND_NEG) : (a_ty + ppmu_pkg::ROUND_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid       <= 1'b0;
      a_valid       <= 1'b0;
      r_valid       <= 1'b0;
      updates.valid <= 1'b0;
    end else if (advance) begin
      m_valid       <= vld[NSTAGE];
      a_valid       <= m_valid;
      r_valid       <= a_valid;
      updates.valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_xf   <= xf_full[61:0];
      m_yl   <= yl_full[61:0];
      m_yf   <= yf_full[61:0];
      m_xl   <= xl_full[61:0];
      m_item <= item[NSTAGE];

      a_tx   <= m_xf - m_yl;
      a_ty   <= m_yf + m_xl;
      a_item <= m_item;

      r_dx   <= tx_round[61:30];
      r_dy   <= ty_round[61:30];
      r_item <= a_item;

      updates.new_x       <= r_item.pose_x + $signed(r_dx) + $signed(r_item.noise_x);
      updates.new_y       <= r_item.pose_y + $signed(r_dy) + $signed(r_item.noise_y);
      updates.new_heading <= r_item.pose_heading + r_item.step_turn + r_item.noise_heading;
      updates.batch_end   <= r_item.batch_last;
    end
  end

  // An accepted particle always lands in the first pipeline stage.
  assert property (@(posedge clk) disable iff (rst)
    (particles.valid && particles.ready) |=> vld[0])
    else $error("accepted particle did not enter the pipeline");

  // While a finished pose waits, no particle moves anywhere in the pipeline.
  assert property (@(posedge clk) disable iff (rst)
    (updates.valid && !updates.ready) |=> $stable({vld, m_valid, a_valid, r_valid}))
    else $error("pipeline moved while the output was stalled");

  // Reset empties the output, the rounding stage and the first stage.
  assert property (@(posedge clk)
    rst |=> (!updates.valid && !vld[0] && !r_valid))
    else $error("pipeline not empty after reset");

endmodule

// ===== tb/sv/particle_pose_motion_update_test.sv =====
// Self-checking testbench for particle_pose_motion_update: a directed table and
// random particles, with a CORDIC pose predictor and a queue of expected poses.
// Depends on ppmu_pkg, ppmu_if and the RTL of particle_pose_motion_update.
module particle_pose_motion_update_test;

  localparam int CORDIC_STAGES = 16;
  localparam int NSTAGE = CORDIC_STAGES > 24 ? 24 : CORDIC_STAGES;
  localparam int PIPE_LATENCY = NSTAGE + 5;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_ITEMS = 200;
  localparam longint ROT_GAIN = 652032874;
  localparam longint HALF_Q30 = 536870912;
  localparam longint HALF_Q12 = 2048;
  localparam longint QUARTER = 16384;
  localparam longint HALF_TURN = 32768;

  typedef struct packed {
    bit signed [31:0] pose_x;
    bit signed [31:0] pose_y;
    bit [15:0]        pose_heading;
    bit signed [31:0] step_forward;
    bit signed [31:0] step_lateral;
    bit [15:0]        step_turn;
    bit signed [15:0] draw_x;
    bit signed [15:0] draw_y;
    bit signed [15:0] draw_heading;
    bit               batch_last;
  } particle_t;

  typedef struct packed {
    bit signed [31:0] new_x;
    bit signed [31:0] new_y;
    bit [15:0]        new_heading;
    bit               batch_end;
  } pose_t;

  typedef struct packed {
    particle_t p;
    bit        typed;
    pose_t     want;
  } case_row_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  longint arctan_step [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  bit [15:0] probe_headings [12] = '{
    16'h0000, 16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF, 16'h8000,
    16'h8001, 16'hBFFF, 16'hC000, 16'hC001, 16'h2000, 16'hE000
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ppmu_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ppmu_in_if  particles_if ();
  ppmu_out_if updates_if ();

  particle_pose_motion_update #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .particles(particles_if),
    .updates(updates_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  bit [15:0]   disp_x;
  bit [15:0]   disp_y;
  bit [13:0]   disp_heading;
  pose_t       pose_queue [$];
  case_row_t   directed_rows [$];
  int          error_count = 0;
  int unsigned cycle_count = 0;
  bit          cur_typed;
  pose_t       cur_want;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  int          stall_left = 0;

  function automatic void unit_vector(input bit [15:0] heading, output longint cos_q30,
                                      output longint sin_q30);
    longint ang, vx, vy, resid, nxt;
    bit flip;
    ang = longint'($signed(heading));
    flip = 1'b0;
    // Fold the angle into one half plane and negate the vector afterwards.
    if (ang > QUARTER) begin
      ang -= HALF_TURN;
      flip = 1'b1;
    end else if (ang < -QUARTER) begin
      ang += HALF_TURN;
      flip = 1'b1;
    end
    resid = ang * 65536;
    vx = ROT_GAIN;
    vy = 0;
    for (int i = 0; i < NSTAGE; i++) begin
      if (resid >= 0) begin
        nxt = vx - (vy >>> i);
        vy = vy + (vx >>> i);
        resid -= arctan_step[i];
      end else begin
        nxt = vx + (vy >>> i);
        vy = vy - (vx >>> i);
        resid += arctan_step[i];
      end
      vx = nxt;
    end
    cos_q30 = flip ? -vx : vx;
    sin_q30 = flip ? -vy : vy;
  endfunction

  function automatic pose_t advance_pose(input particle_t p);
    longint c, s, fwd, lat, dx, dy, nx, ny, nh;
    pose_t r;
    unit_vector(p.pose_heading, c, s);
    fwd = longint'(p.step_forward);
    lat = longint'(p.step_lateral);
    dx = (c * fwd - s * lat + HALF_Q30) >>> 30;
    dy = (s * fwd + c * lat + HALF_Q30) >>> 30;
    nx = (longint'(p.draw_x) * longint'(disp_x) + HALF_Q12) >>> 12;
    ny = (longint'(p.draw_y) * longint'(disp_y) + HALF_Q12) >>> 12;
    nh = (longint'(p.draw_heading) * longint'(disp_heading) + HALF_Q12) >>> 12;
    r.new_x = 32'(longint'(p.pose_x) + dx + nx);
    r.new_y = 32'(longint'(p.pose_y) + dy + ny);
    r.new_heading = 16'(longint'(p.pose_heading) + longint'(p.step_turn) + nh);
    r.batch_end = p.batch_last;
    return r;
  endfunction

  function automatic particle_t make_particle(input int px, input int py, input int ph,
                                              input int fw, input int lt, input int tn,
                                              input int dx, input int dy, input int dh,
                                              input bit last);
    particle_t p;
    p.pose_x = px;
    p.pose_y = py;
    p.pose_heading = ph[15:0];
    p.step_forward = fw;
    p.step_lateral = lt;
    p.step_turn = tn[15:0];
    p.draw_x = dx[15:0];
    p.draw_y = dy[15:0];
    p.draw_heading = dh[15:0];
    p.batch_last = last;
    return p;
  endfunction

  function automatic pose_t make_pose(input int x, input int y, input int h, input bit e);
    pose_t r;
    r.new_x = x;
    r.new_y = y;
    r.new_heading = h[15:0];
    r.batch_end = e;
    return r;
  endfunction

  // Mostly no gap, some short ones and now and then a long one.
  function automatic int idle_span(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [31:0] rand_coord();
    bit [31:0] corner [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(0, 9))
      0: return corner[$urandom_range(0, 3)];
      1, 2, 3: return $urandom;
      default: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic bit [15:0] rand_draw();
    bit [15:0] corner [3] = '{16'h8000, 16'h7FFF, 16'h0000};
    case ($urandom_range(0, 9))
      0: return corner[$urandom_range(0, 2)];
      1, 2: return $urandom;
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic bit [15:0] rand_angle();
    if ($urandom_range(0, 4) == 0)
      return 16'($urandom_range(0, 3) * 16384 + int'($urandom_range(0, 4)) - 2);
    return $urandom;
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    p.pose_x = rand_coord();
    p.pose_y = rand_coord();
    p.pose_heading = rand_angle();
    p.step_forward = rand_coord();
    p.step_lateral = rand_coord();
    p.step_turn = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'(int'($urandom_range(0, 4000)) - 2000);
    p.draw_x = rand_draw();
    p.draw_y = rand_draw();
    p.draw_heading = rand_draw();
    p.batch_last = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  task automatic add_row(input particle_t p, input bit typed, input pose_t want);
    case_row_t row;
    row.p = p;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic drive_particle(input particle_t p);
    particles_if.pose_x = p.pose_x;
    particles_if.pose_y = p.pose_y;
    particles_if.pose_heading = p.pose_heading;
    particles_if.step_forward = p.step_forward;
    particles_if.step_lateral = p.step_lateral;
    particles_if.step_turn = p.step_turn;
    particles_if.draw_x = p.draw_x;
    particles_if.draw_y = p.draw_y;
    particles_if.draw_heading = p.draw_heading;
    particles_if.batch_last = p.batch_last;
  endtask

  // Entered and left at a falling edge; valid stays high for a following item.
  task automatic send_particle(input particle_t p, input bit typed, input pose_t want);
    int gap;
    if ($urandom_range(0, 49) == 0) src_quiet = !src_quiet;
    gap = idle_span(src_quiet);
    repeat (gap) begin
      particles_if.valid = 1'b0;
      @(negedge clk);
    end
    drive_particle(p);
    cur_typed = typed;
    cur_want = want;
    particles_if.valid = 1'b1;
    do @(posedge clk); while (!particles_if.ready);
    @(negedge clk);
  endtask

  task automatic write_disp(input logic [1:0] code, input bit [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {code, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (code)
      ppmu_pkg::REG_DISP_X:       disp_x = value[15:0];
      ppmu_pkg::REG_DISP_Y:       disp_y = value[15:0];
      ppmu_pkg::REG_DISP_HEADING: disp_heading = value[13:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_disp(input logic [1:0] code, input bit [31:0] want);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {code, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata at register %0d: expected %h, actual %h", code, want, prdata);
      error_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Wait until every pose has come back and the pipeline has run dry.
  task automatic settle();
    particles_if.valid = 1'b0;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) sink_quiet = !sink_quiet;
    if (stall_left > 0) begin
      updates_if.ready = 1'b0;
      stall_left--;
    end else begin
      updates_if.ready = 1'b1;
      stall_left = idle_span(sink_quiet);
    end
  end

  // Results are checked before the particle accepted on the same edge is queued.
  always @(posedge clk) begin
    pose_t want;
    particle_t seen;
    if (!rst) begin
      if (updates_if.valid && updates_if.ready) begin
        if (pose_queue.size() == 0) begin
          $error("pose transfer with no particle outstanding");
          error_count++;
        end else begin
          want = pose_queue.pop_front();
          if (updates_if.new_x !== want.new_x) begin
            $error("new_x: expected %0d, actual %0d", want.new_x, updates_if.new_x);
            error_count++;
          end
          if (updates_if.new_y !== want.new_y) begin
            $error("new_y: expected %0d, actual %0d", want.new_y, updates_if.new_y);
            error_count++;
          end
          if (updates_if.new_heading !== want.new_heading) begin
            $error("new_heading: expected %h, actual %h", want.new_heading,
                   updates_if.new_heading);
            error_count++;
          end
          if (updates_if.batch_end !== want.batch_end) begin
            $error("batch_end: expected %b, actual %b", want.batch_end, updates_if.batch_end);
            error_count++;
          end
        end
      end
      if (particles_if.valid && particles_if.ready) begin
        seen = make_particle(particles_if.pose_x, particles_if.pose_y,
                             particles_if.pose_heading, particles_if.step_forward,
                             particles_if.step_lateral, particles_if.step_turn,
                             particles_if.draw_x, particles_if.draw_y,
                             particles_if.draw_heading, particles_if.batch_last);
        pose_queue.push_back(cur_typed ? cur_want : advance_pose(seen));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    bit [31:0] setting [3];
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    particles_if.valid = 1'b0;
    drive_particle('0);
    updates_if.ready = 1'b1;
    cur_typed = 1'b0;
    cur_want = '0;
    disp_x = ppmu_pkg::DISP_X_RESET;
    disp_y = ppmu_pkg::DISP_Y_RESET;
    disp_heading = ppmu_pkg::DISP_HEADING_RESET;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    check_disp(ppmu_pkg::REG_DISP_X, {16'd0, disp_x});
    check_disp(ppmu_pkg::REG_DISP_Y, {16'd0, disp_y});
    check_disp(ppmu_pkg::REG_DISP_HEADING, {18'd0, disp_heading});

    // Zero step leaves the position alone; the heading wraps modulo one turn.
    add_row(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_pose(0, 0, 0, 0));
    add_row(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 16'h1234, 0, 0, 0, 0, 0, 0, 1), 1,
            make_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h1234, 1));
    add_row(make_particle(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 0, 0, 1, 0, 0, 0, 0), 1,
            make_pose(32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    add_row(make_particle(0, 0, 16'h8000, 0, 0, 16'hFFFF, 0, 0, 0, 1), 1,
            make_pose(0, 0, 16'h7FFF, 1));
    // One sigma and full-scale draws at the reset dispersions.
    add_row(make_particle(0, 0, 0, 0, 0, 0, 4096, -4096, 4096, 0), 1,
            make_pose(3277, -3277, 500, 0));
    add_row(make_particle(100, -100, 16'h0100, 0, 0, 0, 32767, 32767, 32767, 0), 0, '0);
    add_row(make_particle(100, -100, 16'h0100, 0, 0, 0, -32768, -32768, -32768, 1), 0, '0);
    // Headings around the quarter and half turn folds.
    foreach (probe_headings[i])
      add_row(make_particle(0, 0, probe_headings[i], 65536, 32768, 0, 0, 0, 0, 0), 0, '0);
    // Steps large enough to wrap the position.
    add_row(make_particle(32'h7FFF_0000, 32'h8000_0000, 16'h2000, 32'h7FFF_FFFF,
                          32'h8000_0000, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hA000, 32'h8000_0000,
                          32'h8000_0000, 16'h8000, -32768, 32767, 0, 1), 0, '0);

    foreach (directed_rows[i])
      send_particle(directed_rows[i].p, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        0: setting = '{32'd0, 32'd0, 32'd0};
        1: setting = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        default: setting = '{$urandom, $urandom, $urandom};
      endcase
      write_disp(ppmu_pkg::REG_DISP_X, setting[0]);
      write_disp(ppmu_pkg::REG_DISP_Y, setting[1]);
      write_disp(ppmu_pkg::REG_DISP_HEADING, setting[2]);
      check_disp(ppmu_pkg::REG_DISP_X, {16'd0, disp_x});
      check_disp(ppmu_pkg::REG_DISP_Y, {16'd0, disp_y});
      check_disp(ppmu_pkg::REG_DISP_HEADING, {18'd0, disp_heading});
      repeat (PHASE_ITEMS) send_particle(random_particle(), 1'b0, '0);
    end

    settle();
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
